// ===== design/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit share allocator package
// Shared types, constants and sequencer states for the allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int unsigned MAX_UNITS_DEF = 8;

  localparam logic [6:0] FULL_SHARE   = 7'd100;
  localparam logic [6:0] NO_FIT_BOUND = 7'd101;

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } bfsa_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RLS,
    ST_UPDATE
  } bfsa_state_e;

  typedef struct packed {
    bfsa_action_e action;
    logic [6:0]   amount;
    logic [2:0]   unit_index;
  } bfsa_req_t;

  typedef struct packed {
    logic [2:0] chosen_unit;
    logic       fell_back;
    logic [6:0] remaining;
  } bfsa_rsp_t;

endpackage

// ===== design/best_fit_share_allocator_unit.sv =====
// Sequence: an allocate reads the share of every active unit in turn (1 to 8 by default),
// folds the last read into the trackers as the scan exits, then writes back in one update;
// a release reads one share and writes it back. busy falls with the result strobe and the
// next start is taken at the edge that ends it, so a new request waits for the last result.
// Reset: all shares read as 100 (valid bits cleared), unit count is 1, block is idle.
// The receiver cannot stall: each result is shown for exactly one cycle on done_o.
// ----------------------------------------------------------------------------
// Best-fit share allocator unit
// Tracks free capacity per compute unit; allocates by best fit with a
// most-free fallback, and takes releases back with saturation at 100.
// ----------------------------------------------------------------------------
module best_fit_share_allocator_unit #(
  parameter int unsigned MAX_UNITS = bfsa_pkg::MAX_UNITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bfsa_pkg::bfsa_req_t req_i,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  output logic                done_o,
  output bfsa_pkg::bfsa_rsp_t rsp_o
);

  localparam int unsigned IdxW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned CntW = $clog2(MAX_UNITS + 1);

  // Sequencer and request hold
  bfsa_pkg::bfsa_state_e state_q, state_d;
  bfsa_pkg::bfsa_req_t   req_q, req_d;
  logic [3:0]            unit_count_q;

  // Scan counter and compare pipeline stage
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;

  // Running best fit and most free trackers
  logic [6:0]      best_q, best_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            found_q, found_d;
  logic [6:0]      most_q, most_d;
  logic [IdxW-1:0] most_idx_q, most_idx_d;

  // Share memory: one read port with registered data, one write port
  logic [6:0]           mem_q [MAX_UNITS];
  logic [MAX_UNITS-1:0] valid_q;
  logic [6:0]           rdata_q;
  logic                 rbit_q;
  logic [IdxW-1:0]      rd_addr;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [6:0]           wr_data;

  // Result register
  logic                done_q, done_d;
  bfsa_pkg::bfsa_rsp_t rsp_q, rsp_d;

  // Derived values
  logic [CntW-1:0] n_active;
  logic [6:0]      share;
  logic            idx_ok;
  logic [6:0]      sel_share;
  logic [IdxW-1:0] sel_idx;
  logic [7:0]      rel_sum;
  logic [6:0]      rel_sat;
  logic [6:0]      alloc_left;

  // Clamp the unit count into 1..MAX_UNITS
  always_comb begin
    if (unit_count_q == 4'd0) begin
      n_active = CntW'(1);
    end else if (32'(unit_count_q) > 32'(MAX_UNITS)) begin
      n_active = CntW'(MAX_UNITS);
    end else begin
      n_active = CntW'(unit_count_q);
    end
  end

  // An entry never written reads as a full share
  assign share  = rbit_q ? rdata_q : bfsa_pkg::FULL_SHARE;
  assign idx_ok = 32'(req_q.unit_index) < 32'(n_active);

  assign sel_share  = found_q ? best_q : most_q;
  assign sel_idx    = found_q ? best_idx_q : most_idx_q;
  assign alloc_left = (sel_share > req_q.amount) ? (sel_share - req_q.amount) : 7'd0;
  assign rel_sum    = {1'b0, share} + {1'b0, req_q.amount};
  assign rel_sat    = (rel_sum > {1'b0, bfsa_pkg::FULL_SHARE}) ? bfsa_pkg::FULL_SHARE
                                                               : rel_sum[6:0];

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    found_d    = found_q;
    most_d     = most_q;
    most_idx_d = most_idx_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;

    // Compare stage: fold the share read last cycle into both trackers
    if (cmp_vld_q) begin
      if ((share >= req_q.amount) && (share < best_q)) begin
        best_d     = share;
        best_idx_d = cmp_idx_q;
        found_d    = 1'b1;
      end
      // Strict greater keeps the lowest index on ties
      if ((cmp_idx_q == '0) || (share > most_q)) begin
        most_d     = share;
        most_idx_d = cmp_idx_q;
      end
    end

    unique case (state_q)
      bfsa_pkg::ST_IDLE: begin
        if (start) begin
          req_d      = req_i;
          cnt_d      = '0;
          best_d     = bfsa_pkg::NO_FIT_BOUND;
          best_idx_d = '0;
          found_d    = 1'b0;
          most_d     = '0;
          most_idx_d = '0;
          state_d    = (req_i.action == bfsa_pkg::ACT_ALLOC) ? bfsa_pkg::ST_SCAN
                                                             : bfsa_pkg::ST_RLS;
        end
      end
      bfsa_pkg::ST_SCAN: begin
        // Issue one read per cycle; the last compare runs as the scan exits
        if (cnt_q < n_active) begin
          rd_addr   = cnt_q[IdxW-1:0];
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[IdxW-1:0];
          cnt_d     = cnt_q + CntW'(1);
        end else begin
          state_d = bfsa_pkg::ST_UPDATE;
        end
      end
      bfsa_pkg::ST_RLS: begin
        rd_addr = idx_ok ? IdxW'(req_q.unit_index) : '0;
        state_d = bfsa_pkg::ST_UPDATE;
      end
      bfsa_pkg::ST_UPDATE: begin
        done_d  = 1'b1;
        state_d = bfsa_pkg::ST_IDLE;
        if (req_q.action == bfsa_pkg::ACT_ALLOC) begin
          wr_en             = 1'b1;
          wr_addr           = sel_idx;
          wr_data           = alloc_left;
          rsp_d.chosen_unit = 3'(sel_idx);
          rsp_d.fell_back   = !found_q;
          rsp_d.remaining   = alloc_left;
        end else begin
          // Release to an inactive unit changes nothing and reports zero
          wr_en             = idx_ok;
          wr_addr           = IdxW'(req_q.unit_index);
          wr_data           = rel_sat;
          rsp_d.chosen_unit = req_q.unit_index;
          rsp_d.fell_back   = 1'b0;
          rsp_d.remaining   = idx_ok ? rel_sat : 7'd0;
        end
      end
      default: begin
        state_d = bfsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bfsa_pkg::ST_IDLE;
      unit_count_q <= 4'd1;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      done_q       <= 1'b0;
      valid_q      <= '0;
      rbit_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
      rbit_q    <= valid_q[rd_addr];
      if (cfg_we_i) begin
        unit_count_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    cmp_idx_q  <= cmp_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    found_q    <= found_d;
    most_q     <= most_d;
    most_idx_q <= most_idx_d;
    rsp_q      <= rsp_d;
  end

  // Share memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign busy   = (state_q != bfsa_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== dv/bfsa_share_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Share allocator checker
// Watches the request, configuration and result channels of the allocator,
// predicts every result from its own copy of the shares and compares in order.
// ----------------------------------------------------------------------------
module bfsa_share_checker #(
  parameter int unsigned MAX_UNITS = bfsa_pkg::MAX_UNITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  bfsa_pkg::bfsa_req_t req_i,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  input  logic                done_i,
  input  bfsa_pkg::bfsa_rsp_t rsp_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_seen_o,
  output int                  fallbacks_seen_o
);

  logic [6:0]          share_q [MAX_UNITS];
  logic [3:0]          unit_cnt_q;
  bfsa_pkg::bfsa_rsp_t expected_rsp_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // Apply one request to the shadow shares and return the result it causes.
  function automatic bfsa_pkg::bfsa_rsp_t predict_share(input bfsa_pkg::bfsa_req_t r);
    int unsigned         n;
    int unsigned         best;
    int unsigned         pick;
    int unsigned         sum;
    int unsigned         i;
    bit                  found;
    bfsa_pkg::bfsa_rsp_t o;
    n = (unit_cnt_q == 0) ? 1 : ((unit_cnt_q > MAX_UNITS) ? MAX_UNITS : unit_cnt_q);
    o = '0;
    if (r.action == bfsa_pkg::ACT_ALLOC) begin
      best  = bfsa_pkg::NO_FIT_BOUND;
      pick  = 0;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
        if (share_q[i] >= r.amount && share_q[i] < best) begin
          pick  = i;
          best  = share_q[i];
          found = 1'b1;
        end
      end
      if (!found) begin
        // Nothing covers the demand: take the lowest-indexed most-free unit.
        pick = 0;
        for (i = 1; i < n; i++) begin
          if (share_q[i] > share_q[pick]) pick = i;
        end
        o.fell_back = 1'b1;
      end
      share_q[pick] = (share_q[pick] > r.amount) ? share_q[pick] - r.amount : 7'd0;
      o.chosen_unit = 3'(pick);
      o.remaining   = share_q[pick];
    end else begin
      o.chosen_unit = r.unit_index;
      if (r.unit_index < n) begin
        sum = share_q[r.unit_index] + r.amount;
        if (sum > bfsa_pkg::FULL_SHARE) sum = bfsa_pkg::FULL_SHARE;
        share_q[r.unit_index] = 7'(sum);
        o.remaining = 7'(sum);
      end
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    bfsa_pkg::bfsa_rsp_t exp_rsp;
    int                  i;
    if (!rst_ni) begin
      for (i = 0; i < MAX_UNITS; i++) share_q[i] = bfsa_pkg::FULL_SHARE;
      unit_cnt_q = 4'd1;
      expected_rsp_q.delete();
      fail_count_o     = 0;
      results_seen_o   = 0;
      fallbacks_seen_o = 0;
    end else begin
      // Retire the finished result before taking a new request on the same edge.
      if (done_i === 1'b1) begin
        results_seen_o++;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result with nothing pending", int'(rsp_i), 0);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (exp_rsp.fell_back) fallbacks_seen_o++;
          if (rsp_i.chosen_unit !== exp_rsp.chosen_unit)
            report_mismatch("chosen_unit", rsp_i.chosen_unit, exp_rsp.chosen_unit);
          if (rsp_i.fell_back !== exp_rsp.fell_back)
            report_mismatch("fell_back", rsp_i.fell_back, exp_rsp.fell_back);
          if (rsp_i.remaining !== exp_rsp.remaining)
            report_mismatch("remaining", rsp_i.remaining, exp_rsp.remaining);
        end
      end
      if (cfg_we_i === 1'b1) unit_cnt_q = cfg_wdata_i;
      // Append the prediction at the tail so results retire in request order.
      if (start_i === 1'b1 && busy_i === 1'b0)
        expected_rsp_q = {expected_rsp_q, predict_share(req_i)};
    end
    pending_o = expected_rsp_q.size();
  end

endmodule

// ===== dv/best_fit_share_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit share allocator testbench
// Drives directed corner cases and then random allocate/release traffic under
// a range of unit counts; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module best_fit_share_allocator_unit_tb;

  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 65;
  localparam int TAIL_CYCLES  = 20;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  bfsa_pkg::bfsa_req_t req;
  logic                cfg_we;
  logic [3:0]          cfg_wdata;
  logic                done;
  bfsa_pkg::bfsa_rsp_t rsp;

  int fail_count;
  int pending;
  int results_seen;
  int fallbacks_seen;
  int settings_used;

  // Unit counts for the random phases; 0 and 15 probe the clamping at both ends.
  int unsigned phase_unit_count [PHASES] = '{8, 4, 1, 15, 0, 6, 8, 2, 7, 3};

  best_fit_share_allocator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .done_o      (done),
    .rsp_o       (rsp)
  );

  bfsa_share_checker u_share_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .done_i           (done),
    .rsp_i            (rsp),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_seen_o   (results_seen),
    .fallbacks_seen_o (fallbacks_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: the slowest legal run is well under a millisecond.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bfsa_pkg::bfsa_req_t mk_req(input bfsa_pkg::bfsa_action_e act,
                                                 input int amt, input int idx);
    bfsa_pkg::bfsa_req_t r;
    r.action     = act;
    r.amount     = 7'(amt);
    r.unit_index = 3'(idx);
    return r;
  endfunction

  // Mostly legal demands with a bias toward small ones so shares spread out;
  // a slice above 100 keeps the fallback path and the top amount bits busy.
  function automatic bfsa_pkg::bfsa_req_t rand_req();
    bfsa_pkg::bfsa_req_t r;
    int                  sel;
    r.action     = ($urandom_range(0, 99) < 60) ? bfsa_pkg::ACT_ALLOC : bfsa_pkg::ACT_RELEASE;
    r.unit_index = 3'($urandom_range(0, 7));
    sel = $urandom_range(0, 99);
    if (sel < 45)      r.amount = 7'($urandom_range(0, 35));
    else if (sel < 85) r.amount = 7'($urandom_range(0, 100));
    else if (sel < 95) r.amount = 7'($urandom_range(101, 127));
    else               r.amount = ($urandom_range(0, 1) != 0) ? bfsa_pkg::FULL_SHARE : 7'd0;
    return r;
  endfunction

  // Gap before the next request: mostly none or short, now and then long.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Call at a falling edge; return at the falling edge after the transfer,
  // with start still high so a back-to-back request keeps it up.
  task automatic issue_req(input bfsa_pkg::bfsa_req_t r, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req   = r;
    start = 1'b1;
    // Busy only moves on a rising edge, so its value here decides the next edge.
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Drop start and hold off until every expected result has come back.
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_unit_count(input int unsigned cnt);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = 4'(cnt);
    @(negedge clk);
    cfg_we    = 1'b0;
    settings_used++;
  endtask

  initial begin
    bfsa_pkg::bfsa_req_t dir_q [$];
    int                  ph;
    int                  k;

    start         = 1'b0;
    req           = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = 4'd0;
    rst_n         = 1'b0;
    settings_used = 1;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Single unit out of reset: exact fit, empty unit, overflowing release,
    // release to an inactive unit and demands above full capacity.
    dir_q = '{mk_req(bfsa_pkg::ACT_ALLOC, 0, 0),     mk_req(bfsa_pkg::ACT_ALLOC, 100, 5),
              mk_req(bfsa_pkg::ACT_ALLOC, 1, 0),     mk_req(bfsa_pkg::ACT_RELEASE, 127, 0),
              mk_req(bfsa_pkg::ACT_RELEASE, 5, 7),   mk_req(bfsa_pkg::ACT_RELEASE, 0, 0),
              mk_req(bfsa_pkg::ACT_ALLOC, 101, 0),   mk_req(bfsa_pkg::ACT_RELEASE, 100, 0),
              mk_req(bfsa_pkg::ACT_ALLOC, 127, 7)};
    foreach (dir_q[i]) issue_req(dir_q[i], pick_gap());

    // All eight units: best fit over partial shares, ties to the lowest index,
    // fallback with several equally free units, saturating release.
    set_unit_count(8);
    dir_q = '{mk_req(bfsa_pkg::ACT_ALLOC, 60, 0),    mk_req(bfsa_pkg::ACT_ALLOC, 30, 0),
              mk_req(bfsa_pkg::ACT_ALLOC, 50, 0),    mk_req(bfsa_pkg::ACT_ALLOC, 50, 0),
              mk_req(bfsa_pkg::ACT_ALLOC, 100, 0),   mk_req(bfsa_pkg::ACT_RELEASE, 7, 5),
              mk_req(bfsa_pkg::ACT_ALLOC, 127, 0),   mk_req(bfsa_pkg::ACT_ALLOC, 90, 0),
              mk_req(bfsa_pkg::ACT_ALLOC, 101, 0),   mk_req(bfsa_pkg::ACT_RELEASE, 45, 7),
              mk_req(bfsa_pkg::ACT_ALLOC, 10, 0)};
    foreach (dir_q[i]) issue_req(dir_q[i], pick_gap());

    // Count above the unit limit clamps to eight; count zero clamps to one.
    set_unit_count(15);
    issue_req(mk_req(bfsa_pkg::ACT_RELEASE, 3, 7), 0);
    issue_req(mk_req(bfsa_pkg::ACT_ALLOC, 0, 0), 0);
    set_unit_count(0);
    issue_req(mk_req(bfsa_pkg::ACT_RELEASE, 20, 1), 0);
    issue_req(mk_req(bfsa_pkg::ACT_ALLOC, 64, 3), 0);

    // Random phases, each under its own unit count; each starts idle.
    for (ph = 0; ph < PHASES; ph++) begin
      set_unit_count(phase_unit_count[ph]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Open each phase with a burst of back-to-back transfers.
        issue_req(rand_req(), (k < 15) ? 0 : pick_gap());
        // Once mid-phase, pause until the block has caught up completely.
        if (k == PHASE_ITEMS / 2) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d results, %0d of them fallbacks, across %0d unit-count settings",
             results_seen, fallbacks_seen, settings_used);
    $display("including clamped counts 0 and 15, saturating releases and inactive units");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
